@@ hdl/i2c_rangefinder_register_map_assert.svh @@
// ----------------------------------------------------------------------------
// Rangefinder register map assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef I2C_RANGEFINDER_REGISTER_MAP_ASSERT_SVH
`define I2C_RANGEFINDER_REGISTER_MAP_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define RF_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("rangefinder check failed: label");

// Next-cycle implication, checked only out of reset.
`define RF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("rangefinder check failed: label");

`endif

@@ hdl/i2crf_pkg.sv @@
// ----------------------------------------------------------------------------
// Rangefinder register map package
// Item codes, register addresses and register image constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2crf_pkg;

    localparam int NAME_BYTES = 16;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [7:0] REG_NAME = 8'd0;
    localparam logic [7:0] REG_MASK = 8'd27;
    localparam logic [7:0] REG_DIST = 8'd44;
    localparam logic [7:0] REG_RATE = 8'd74;

    localparam logic [15:0] MIN_CM       = 16'd20;
    localparam logic [15:0] MAX_CM       = 16'd50000;
    localparam logic [7:0]  STRENGTH_VAL = 8'd100;
    localparam logic [12:0] DIST_RESET   = 13'd2;

    // Reciprocal of ten: (x * 0xCCCD) >> 19 is exact for every 16-bit x.
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    // Write message progress.
    localparam logic [2:0] WC_IDLE  = 3'd0;
    localparam logic [2:0] WC_REG   = 3'd1;
    localparam logic [2:0] WC_DATA1 = 3'd2;
    localparam logic [2:0] WC_DATA2 = 3'd3;
    localparam logic [2:0] WC_DATA3 = 3'd4;
    localparam logic [2:0] WC_DONE  = 3'd5;

    localparam logic [4:0] OFFSET_MAX = 5'd31;

    // Byte of the device name image at a given offset.
    function automatic logic [7:0] name_byte(input logic [4:0] off);
        logic [7:0] b;
        case (off)
            5'd0:    b = 8'h47;
            5'd1:    b = 8'h52;
            5'd2:    b = 8'h46;
            5'd3:    b = 8'h32;
            5'd4:    b = 8'h35;
            5'd5:    b = 8'h30;
            default: b = 8'h00;
        endcase
        if (32'(off) >= NAME_BYTES) begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

@@ hdl/i2c_rangefinder_register_map.sv @@
// ----------------------------------------------------------------------------
// Rangefinder bus register map
// Byte-level bus target register file with range sample conditioning.
// ----------------------------------------------------------------------------
// Usage:
// One input channel (i_in_valid / o_in_stall) carries range samples, bus write
// bytes and bus read bytes, told apart by i_kind. A transfer happens at a clock
// edge with valid high and stall low. Every bus read byte gives exactly one
// transfer on the output channel (o_out_valid / i_out_stall) carrying
// o_read_data; all other items give none.
// Each item is captured in an input register, then processed in a single pass
// of short logic that updates the register map and loads the result register.
// Output valid comes from the result register, loaded from the input register,
// and one item is taken every cycle while no read waits on a stalled result.
// The one multiplier (the divide by ten of a range sample) sits in that
// single pass.
// When the receiver stalls, the result register holds its byte. Samples and
// write bytes keep flowing because they produce no output, until a read byte
// reaches the input register; it then waits there and stalls the input side.
// Reset (synchronous, active low) empties both registers and returns the map
// to rate 1, mask 0, distance 2 with strength 0, no open write message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_rangefinder_register_map_assert.svh"

module i2c_rangefinder_register_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_msg_start,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_range_cm,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data
);

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic        r_msg_start;
    logic [7:0]  r_data_byte;
    logic [15:0] r_range_cm;

    // Register map state.
    logic [7:0]  r_reg_pointer, n_reg_pointer;
    logic [7:0]  r_rate_reg,    n_rate_reg;
    logic [31:0] r_mask_reg,    n_mask_reg;
    logic [12:0] r_dist_raw,    n_dist_raw;
    logic        r_dist_strong, n_dist_strong;
    logic [12:0] r_snap_raw,    n_snap_raw;
    logic        r_snap_strong, n_snap_strong;
    logic [4:0]  r_read_offset, n_read_offset;
    logic [2:0]  r_write_count, n_write_count;
    logic [23:0] r_write_accum, n_write_accum;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [7:0]  n_read_data;

    logic        out_blocked;
    logic        proc;
    logic        is_read;
    logic [15:0] clamped_cm;
    logic        sample_strong;
    logic [31:0] recip_product;
    logic [31:0] write_value;
    logic [4:0]  eff_offset;
    logic [12:0] eff_raw;
    logic        eff_strong;
    logic [7:0]  strength_byte;

    assign is_read     = (r_kind == i2crf_pkg::KIND_READ);
    assign out_blocked = r_out_valid && i_out_stall;
    // Only a read needs the result register, so only a read waits for it.
    assign proc        = r_in_valid && !(is_read && out_blocked);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // Range conditioning: clamp, then divide by ten through the reciprocal.
    always_comb begin
        clamped_cm    = r_range_cm;
        sample_strong = 1'b1;
        if (r_range_cm < i2crf_pkg::MIN_CM) begin
            clamped_cm    = i2crf_pkg::MIN_CM;
            sample_strong = 1'b0;
        end
        if (r_range_cm > i2crf_pkg::MAX_CM) begin
            clamped_cm    = i2crf_pkg::MAX_CM;
            sample_strong = 1'b0;
        end
    end

    assign recip_product = clamped_cm * i2crf_pkg::RECIP_TEN;
    assign write_value   = {r_data_byte, r_write_accum};

    // A read that opens a message sees the fresh snapshot at offset zero.
    assign eff_offset    = r_msg_start ? 5'd0 : r_read_offset;
    assign eff_raw       = r_msg_start ? r_dist_raw : r_snap_raw;
    assign eff_strong    = r_msg_start ? r_dist_strong : r_snap_strong;
    assign strength_byte = eff_strong ? i2crf_pkg::STRENGTH_VAL : 8'd0;

    // Register image byte for the selected register.
    always_comb begin
        n_read_data = 8'd0;
        unique case (r_reg_pointer)
            i2crf_pkg::REG_NAME: begin
                n_read_data = i2crf_pkg::name_byte(eff_offset);
            end
            i2crf_pkg::REG_RATE: begin
                if (eff_offset == 5'd0) begin
                    n_read_data = r_rate_reg;
                end
            end
            i2crf_pkg::REG_MASK: begin
                case (eff_offset)
                    5'd0:    n_read_data = r_mask_reg[7:0];
                    5'd1:    n_read_data = r_mask_reg[15:8];
                    5'd2:    n_read_data = r_mask_reg[23:16];
                    5'd3:    n_read_data = r_mask_reg[31:24];
                    default: n_read_data = 8'd0;
                endcase
            end
            i2crf_pkg::REG_DIST: begin
                case (eff_offset)
                    5'd0:    n_read_data = eff_raw[7:0];
                    5'd1:    n_read_data = {3'd0, eff_raw[12:8]};
                    5'd4:    n_read_data = strength_byte;
                    default: n_read_data = 8'd0;
                endcase
            end
            default: n_read_data = 8'd0;
        endcase
    end

    // Next state of the register map for the item in the input register.
    always_comb begin
        n_reg_pointer = r_reg_pointer;
        n_rate_reg    = r_rate_reg;
        n_mask_reg    = r_mask_reg;
        n_dist_raw    = r_dist_raw;
        n_dist_strong = r_dist_strong;
        n_snap_raw    = r_snap_raw;
        n_snap_strong = r_snap_strong;
        n_read_offset = r_read_offset;
        n_write_count = r_write_count;
        n_write_accum = r_write_accum;
        case (r_kind)
            i2crf_pkg::KIND_SAMPLE: begin
                n_dist_raw    = recip_product[i2crf_pkg::RECIP_SHIFT +: 13];
                n_dist_strong = sample_strong;
            end
            i2crf_pkg::KIND_WRITE: begin
                if (r_msg_start) begin
                    n_reg_pointer = r_data_byte;
                    n_write_count = i2crf_pkg::WC_REG;
                    n_write_accum = 24'd0;
                end else begin
                    case (r_write_count)
                        i2crf_pkg::WC_REG: begin
                            n_write_accum = {r_write_accum[23:8], r_data_byte};
                            n_write_count = i2crf_pkg::WC_DATA1;
                        end
                        i2crf_pkg::WC_DATA1: begin
                            n_write_accum = {r_write_accum[23:16], r_data_byte,
                                             r_write_accum[7:0]};
                            n_write_count = i2crf_pkg::WC_DATA2;
                        end
                        i2crf_pkg::WC_DATA2: begin
                            n_write_accum = {r_data_byte, r_write_accum[15:0]};
                            n_write_count = i2crf_pkg::WC_DATA3;
                        end
                        i2crf_pkg::WC_DATA3: begin
                            // Fourth data byte: apply the whole 32-bit value.
                            if (r_reg_pointer == i2crf_pkg::REG_RATE) begin
                                n_rate_reg = (write_value != 32'd0) ?
                                             write_value[7:0] : 8'd1;
                            end else if (r_reg_pointer == i2crf_pkg::REG_MASK) begin
                                n_mask_reg = write_value;
                            end
                            n_write_count = i2crf_pkg::WC_DONE;
                        end
                        default: begin
                            // No open message, or message already applied.
                        end
                    endcase
                end
            end
            i2crf_pkg::KIND_READ: begin
                if (r_msg_start) begin
                    n_snap_raw    = r_dist_raw;
                    n_snap_strong = r_dist_strong;
                    n_write_count = i2crf_pkg::WC_IDLE;
                end
                n_read_offset = (eff_offset == i2crf_pkg::OFFSET_MAX) ?
                                eff_offset : eff_offset + 5'd1;
            end
            default: begin
                // Unknown item kind is dropped.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_reg_pointer <= 8'd0;
            r_rate_reg    <= 8'd1;
            r_mask_reg    <= 32'd0;
            r_dist_raw    <= i2crf_pkg::DIST_RESET;
            r_dist_strong <= 1'b0;
            r_snap_raw    <= i2crf_pkg::DIST_RESET;
            r_snap_strong <= 1'b0;
            r_read_offset <= 5'd0;
            r_write_count <= i2crf_pkg::WC_IDLE;
            r_write_accum <= 24'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_reg_pointer <= n_reg_pointer;
                r_rate_reg    <= n_rate_reg;
                r_mask_reg    <= n_mask_reg;
                r_dist_raw    <= n_dist_raw;
                r_dist_strong <= n_dist_strong;
                r_snap_raw    <= n_snap_raw;
                r_snap_strong <= n_snap_strong;
                r_read_offset <= n_read_offset;
                r_write_count <= n_write_count;
                r_write_accum <= n_write_accum;
            end
            if (proc && is_read) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_kind      <= i_kind;
            r_msg_start <= i_msg_start;
            r_data_byte <= i_data_byte;
            r_range_cm  <= i_range_cm;
        end
        if (proc && is_read) begin
            r_read_data <= n_read_data;
        end
    end

    // A processed read always leaves a byte in the result register.
    `RF_ASSERT_NEXT(a_read_gives_result, i_clk, i_rst_n, proc && is_read, r_out_valid)
    // A stalled result is never dropped.
    `RF_ASSERT_NEXT(a_stalled_result_held, i_clk, i_rst_n,
                    r_out_valid && i_out_stall, r_out_valid)
    // A read that opens a message closes writes and steps past offset zero.
    `RF_ASSERT_NEXT(a_read_start, i_clk, i_rst_n, proc && is_read && r_msg_start,
                    (r_read_offset == 5'd1) && (r_write_count == i2crf_pkg::WC_IDLE))
    // Stored distance stays within the clamped range in tenths of a metre.
    `RF_ASSERT_NEXT(a_dist_range, i_clk, i_rst_n,
                    proc && (r_kind == i2crf_pkg::KIND_SAMPLE),
                    (r_dist_raw >= 13'd2) && (r_dist_raw <= 13'd5000))

endmodule

@@ tb/sv/i2c_rangefinder_register_map_tb.sv @@
// ----------------------------------------------------------------------------
// Rangefinder register map testbench
// Drives range samples and bus write and read bytes through the input channel
// and checks every returned read byte against a register map model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_rangefinder_register_map_tb;

    localparam int          CLK_HALF_NS  = 2;
    localparam int          RESET_CYCLES = 10;
    localparam int          ITEM_TARGET  = 1500;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    // The model of the register map together with the read bytes it owes.
    // note_transfer() advances the model by one accepted input transfer and
    // queues a byte for each bus read; check_read_byte() compares one output
    // transfer with the oldest queued byte.
    class regmap_scoreboard;
        logic [7:0]  sel_reg;
        logic [7:0]  rate_val;
        logic [31:0] mask_val;
        logic [12:0] dist_tenths;
        logic        dist_good;
        logic [12:0] held_tenths;
        logic        held_good;
        logic [4:0]  rd_pos;
        logic [2:0]  wr_stage;
        logic [23:0] wr_bytes;
        logic [7:0]  read_bytes_due[$];
        int          fails;
        int          n_checked;
        int          n_samples;
        int          n_writes;

        function new();
            sel_reg     = i2crf_pkg::REG_NAME;
            rate_val    = 8'd1;
            mask_val    = '0;
            dist_tenths = i2crf_pkg::DIST_RESET;
            dist_good   = 1'b0;
            held_tenths = i2crf_pkg::DIST_RESET;
            held_good   = 1'b0;
            rd_pos      = '0;
            wr_stage    = i2crf_pkg::WC_IDLE;
            wr_bytes    = '0;
            fails       = 0;
            n_checked   = 0;
            n_samples   = 0;
            n_writes    = 0;
        endfunction

        // Byte of the selected register's little-endian image at a read offset.
        function logic [7:0] register_byte(logic [4:0] pos);
            logic [31:0] word;
            logic [7:0]  b;
            b = 8'h00;
            case (sel_reg)
                i2crf_pkg::REG_NAME: begin
                    if (32'(pos) < i2crf_pkg::NAME_BYTES) begin
                        case (pos)
                            5'd0:    b = 8'h47;
                            5'd1:    b = 8'h52;
                            5'd2:    b = 8'h46;
                            5'd3:    b = 8'h32;
                            5'd4:    b = 8'h35;
                            5'd5:    b = 8'h30;
                            default: b = 8'h00;
                        endcase
                    end
                end
                i2crf_pkg::REG_RATE: begin
                    word = {24'd0, rate_val};
                    if (pos < 5'd4) b = word[8 * pos[1:0] +: 8];
                end
                i2crf_pkg::REG_MASK: begin
                    word = mask_val;
                    if (pos < 5'd4) b = word[8 * pos[1:0] +: 8];
                end
                i2crf_pkg::REG_DIST: begin
                    if (pos < 5'd4) begin
                        word = {19'd0, held_tenths};
                        b    = word[8 * pos[1:0] +: 8];
                    end else if (pos < 5'd8) begin
                        word = held_good ? {24'd0, i2crf_pkg::STRENGTH_VAL} : 32'd0;
                        b    = word[8 * pos[1:0] +: 8];
                    end
                end
                default: b = 8'h00;
            endcase
            return b;
        endfunction

        function void note_transfer(i2crf_pkg::t_kind k, logic st, logic [7:0] d,
                                    logic [15:0] cm);
            logic [15:0] c;
            logic        good;
            logic [31:0] word;
            case (k)
                i2crf_pkg::KIND_SAMPLE: begin
                    c    = cm;
                    good = 1'b1;
                    if (c < i2crf_pkg::MIN_CM) begin
                        c    = i2crf_pkg::MIN_CM;
                        good = 1'b0;
                    end
                    if (c > i2crf_pkg::MAX_CM) begin
                        c    = i2crf_pkg::MAX_CM;
                        good = 1'b0;
                    end
                    dist_tenths = 13'(c / 16'd10);
                    dist_good   = good;
                    n_samples++;
                end
                i2crf_pkg::KIND_WRITE: begin
                    n_writes++;
                    if (st) begin
                        sel_reg  = d;
                        wr_stage = i2crf_pkg::WC_REG;
                        wr_bytes = '0;
                    end else if (wr_stage >= i2crf_pkg::WC_REG &&
                                 wr_stage <= i2crf_pkg::WC_DATA2) begin
                        wr_bytes = wr_bytes |
                                   (24'(d) << (8 * (wr_stage - i2crf_pkg::WC_REG)));
                        wr_stage = wr_stage + 3'd1;
                    end else if (wr_stage == i2crf_pkg::WC_DATA3) begin
                        word = {d, wr_bytes};
                        if (sel_reg == i2crf_pkg::REG_RATE) begin
                            // A zero value means the default rate of one.
                            rate_val = (word != 32'd0) ? word[7:0] : 8'd1;
                        end else if (sel_reg == i2crf_pkg::REG_MASK) begin
                            mask_val = word;
                        end
                        wr_stage = i2crf_pkg::WC_DONE;
                    end
                end
                i2crf_pkg::KIND_READ: begin
                    if (st) begin
                        held_tenths = dist_tenths;
                        held_good   = dist_good;
                        rd_pos      = '0;
                        wr_stage    = i2crf_pkg::WC_IDLE;
                    end
                    read_bytes_due.push_back(register_byte(rd_pos));
                    if (rd_pos < i2crf_pkg::OFFSET_MAX) rd_pos = rd_pos + 5'd1;
                end
                default: ;
            endcase
        endfunction

        function void check_read_byte(logic [7:0] got);
            logic [7:0] want;
            if (read_bytes_due.size() == 0) begin
                $error("read_data: no byte expected, actual 0x%02h", got);
                fails++;
            end else begin
                want = read_bytes_due.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("read_data: expected 0x%02h, actual 0x%02h", want, got);
                    fails++;
                end
            end
        endfunction

        function int outstanding();
            return read_bytes_due.size();
        endfunction

        function void close();
            if (read_bytes_due.size() != 0) begin
                $error("read_data: expected %0d more bytes, actual none",
                       read_bytes_due.size());
                fails++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    i2crf_pkg::t_kind  kind = i2crf_pkg::KIND_SAMPLE;
    logic              msg_start = 1'b0;
    logic [7:0]        data_byte = '0;
    logic [15:0]       range_cm = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        read_data;

    // When set, neither side idles; used for one long stretch of the run.
    logic        quiet = 1'b0;
    int          n_items = 0;

    regmap_scoreboard sb = new();

    i2c_rangefinder_register_map u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_kind      (kind),
        .i_msg_start (msg_start),
        .i_data_byte (data_byte),
        .i_range_cm  (range_cm),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_read_data (read_data)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // The receiver holds off about a third of the cycles unless the run is in
    // its quiet stretch. Stall changes only at the falling edge.
    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 33);
    end

    // Both monitors look at the rising edge. The block's outputs update in the
    // nonblocking region, so the values read here are the ones of the edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            sb.note_transfer(kind, msg_start, data_byte, range_cm);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_read_byte(read_data);
        end
    end

    // Presents one item and returns at the falling edge after its transfer.
    // Must be entered at a falling edge. Idle cycles, if any, come first; the
    // payload then stays put until the block takes it.
    task automatic send_item(i2crf_pkg::t_kind k, logic st, logic [7:0] d,
                             logic [15:0] cm);
        while (!quiet && ($urandom_range(0, 99) < 33)) begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            range_cm  <= 16'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        msg_start <= st;
        data_byte <= d;
        range_cm  <= cm;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (k != i2crf_pkg::KIND_NONE) n_items++;
    endtask

    task automatic send_sample(logic [15:0] cm);
        send_item(i2crf_pkg::KIND_SAMPLE, 1'($urandom), 8'($urandom), cm);
    endtask

    // A write message: the register byte, then ndata data bytes taken from the
    // value low byte first. Bytes past the fourth carry random content.
    task automatic write_msg(logic [7:0] reg_sel, int ndata, logic [31:0] value);
        logic [7:0] b;
        send_item(i2crf_pkg::KIND_WRITE, 1'b1, reg_sel, 16'($urandom));
        for (int i = 0; i < ndata; i++) begin
            b = (i < 4) ? value[8 * i +: 8] : 8'($urandom);
            send_item(i2crf_pkg::KIND_WRITE, 1'b0, b, 16'($urandom));
        end
    endtask

    function automatic logic [15:0] pick_range();
        logic [15:0] r;
        case ($urandom_range(0, 5))
            0: r = 16'($urandom_range(0, 19));
            1: r = 16'($urandom_range(50001, 65535));
            2: r = 16'($urandom_range(20, 50000));
            3: begin
                case ($urandom_range(0, 5))
                    0:       r = 16'd0;
                    1:       r = 16'd19;
                    2:       r = 16'd20;
                    3:       r = 16'd50000;
                    4:       r = 16'd50001;
                    default: r = 16'hFFFF;
                endcase
            end
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    // A read message of nbytes bytes. Now and then a range sample slips in
    // between, which must not disturb the distance snapshot.
    task automatic read_msg(int nbytes);
        send_item(i2crf_pkg::KIND_READ, 1'b1, 8'($urandom), 16'($urandom));
        for (int i = 1; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) send_sample(pick_range());
            send_item(i2crf_pkg::KIND_READ, 1'b0, 8'($urandom), 16'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_reg();
        logic [7:0] r;
        case ($urandom_range(0, 6))
            0:       r = i2crf_pkg::REG_NAME;
            1:       r = i2crf_pkg::REG_RATE;
            2:       r = i2crf_pkg::REG_MASK;
            3:       r = i2crf_pkg::REG_DIST;
            4:       r = 8'hFF;
            default: r = 8'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'd0;
            1:       v = 32'h0000_0100;
            2:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_write_len();
        return ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(0, 6);
    endfunction

    // Stray traffic: continuation bytes with no open message, reads without a
    // start, unused kind codes and bare register selects.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(i2crf_pkg::KIND_WRITE, 1'b0, 8'($urandom), 16'($urandom));
            1: send_item(i2crf_pkg::KIND_READ, 1'b0, 8'($urandom), 16'($urandom));
            2: send_item(i2crf_pkg::KIND_NONE, 1'($urandom), 8'($urandom),
                         16'($urandom));
            default: send_item(i2crf_pkg::KIND_WRITE, 1'b1, pick_reg(), 16'($urandom));
        endcase
    endtask

    initial begin
        int guard;
        int sel;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. The clamp cases come first, then the distance
        // register is read across the end of its distance word into the
        // strength word.
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd50000);
        write_msg(i2crf_pkg::REG_DIST, 0, 32'd0);
        read_msg(6);
        send_item(i2crf_pkg::KIND_NONE, 1'b1, 8'h5A, 16'hA5A5);
        // The read start closed the write message, so this byte is dropped.
        send_item(i2crf_pkg::KIND_WRITE, 1'b0, 8'hA5, 16'h0000);
        // A rate of 256 keeps only its low byte, giving rate zero. The fifth
        // data byte is beyond the value and must be ignored.
        write_msg(i2crf_pkg::REG_RATE, 5, 32'h0000_0100);
        read_msg(2);
        // A short write only moves the register pointer.
        write_msg(i2crf_pkg::REG_MASK, 2, 32'hFFFF_FFFF);
        read_msg(1);

        // Random part: mostly complete messages, with the quiet stretch in
        // the middle.
        while (n_items < ITEM_TARGET) begin
            quiet = (n_items >= 600 && n_items < 900);
            sel   = $urandom_range(0, 99);
            if (sel < 25) begin
                send_sample(pick_range());
            end else if (sel < 55) begin
                write_msg(pick_reg(), pick_write_len(), pick_value());
            end else if (sel < 90) begin
                // An occasional long read runs the offset into saturation.
                read_msg(($urandom_range(0, 19) == 0) ? 36 : $urandom_range(1, 12));
            end else begin
                send_noise();
            end
        end
        in_valid <= 1'b0;

        guard = 0;
        while (sb.outstanding() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close();

        $display("Run covered %0d items: %0d range samples, %0d bus write bytes,",
                 n_items, sb.n_samples, sb.n_writes);
        $display("and %0d read bytes compared against the register images.", sb.n_checked);
        if (sb.fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest plausible correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
